// ----- hdl/bpf_pkg.sv -----
// Shared opcodes and instruction class type for the bytecode peephole fuser.
package bpf_pkg;

    // VM opcodes
    localparam logic [7:0] OP_COPY     = 8'h03;
    localparam logic [7:0] OP_PUSH     = 8'h04;
    localparam logic [7:0] OP_ADD      = 8'h06;
    localparam logic [7:0] OP_SUB      = 8'h07;
    localparam logic [7:0] OP_MUL      = 8'h08;
    localparam logic [7:0] OP_DIV      = 8'h09;
    localparam logic [7:0] OP_MOD      = 8'h0A;
    localparam logic [7:0] OP_SHR      = 8'h0F;
    localparam logic [7:0] OP_SHL      = 8'h10;
    localparam logic [7:0] OP_OR       = 8'h11;
    localparam logic [7:0] OP_AND      = 8'h12;
    localparam logic [7:0] OP_XOR      = 8'h13;
    localparam logic [7:0] OP_CMP      = 8'h14;
    localparam logic [7:0] OP_NOP      = 8'h28;
    localparam logic [7:0] OP_SWAP     = 8'h29;
    localparam logic [7:0] OP_FASTCMP  = 8'h32;
    localparam logic [7:0] OP_GOTO_F   = 8'h36;
    localparam logic [7:0] OP_GOTO_EQ  = 8'h37;
    localparam logic [7:0] OP_GOTO_NE  = 8'h38;
    localparam logic [7:0] OP_GOTO_GT  = 8'h39;
    localparam logic [7:0] OP_GOTO_LT  = 8'h3A;
    localparam logic [7:0] OP_GOTO_NGT = 8'h3B;
    localparam logic [7:0] OP_GOTO_NLT = 8'h3C;
    localparam logic [7:0] OP_NONE     = 8'h00;

    // Decoded instruction class; inv_op is the inverted goto for a FastCompare
    // condition code, OP_NONE when the code is unknown.
    typedef struct packed {
        logic       is_copy;
        logic       is_push;
        logic       is_binop;
        logic       is_swap;
        logic       is_fastcmp;
        logic       is_gotof;
        logic       is_nop;
        logic [7:0] inv_op;
    } t_class;

endpackage

// ----- hdl/bpf_front.sv -----
// Front end: decodes incoming instructions and queues them for the window engine.
module bpf_front #(
    parameter int AW = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    output logic                  o_full,
    input  logic [7:0]            i_opcode,
    input  logic [AW-1:0]         i_arg_a,
    input  logic [AW-1:0]         i_arg_b,
    input  logic [AW-1:0]         i_arg_c,
    input  logic                  i_final,
    output logic                  o_vld,
    input  logic                  i_rd,
    output logic [7:0]            o_opcode,
    output bpf_pkg::t_class       o_cls,
    output logic [AW-1:0]         o_arg [3],
    output logic                  o_final
);

    localparam int IQ_DEPTH = 4;
    localparam int IQ_AW    = $clog2(IQ_DEPTH);
    localparam int IQ_CW    = $clog2(IQ_DEPTH + 1);

    localparam int unsigned CC_EQ = 1;
    localparam int unsigned CC_NE = 2;
    localparam int unsigned CC_LT = 4;
    localparam int unsigned CC_GT = 8;
    localparam int unsigned CC_LE = 16;
    localparam int unsigned CC_GE = 32;

    bpf_pkg::t_class  cls;
    logic             wr;
    logic             rd;

    logic [7:0]       r_q_op  [IQ_DEPTH];
    bpf_pkg::t_class  r_q_cls [IQ_DEPTH];
    logic [AW-1:0]    r_q_arg [IQ_DEPTH][3];
    logic             r_q_fin [IQ_DEPTH];
    logic [IQ_AW-1:0] r_wp;
    logic [IQ_AW-1:0] r_rp;
    logic [IQ_CW-1:0] r_cnt;

    // Classify the incoming word
    always_comb begin
        cls            = '0;
        cls.is_copy    = (i_opcode == bpf_pkg::OP_COPY);
        cls.is_push    = (i_opcode == bpf_pkg::OP_PUSH);
        cls.is_swap    = (i_opcode == bpf_pkg::OP_SWAP);
        cls.is_fastcmp = (i_opcode == bpf_pkg::OP_FASTCMP);
        cls.is_gotof   = (i_opcode == bpf_pkg::OP_GOTO_F);
        cls.is_nop     = (i_opcode == bpf_pkg::OP_NOP);
        case (i_opcode) inside
            bpf_pkg::OP_ADD, bpf_pkg::OP_SUB, bpf_pkg::OP_MUL, bpf_pkg::OP_DIV,
            bpf_pkg::OP_MOD, bpf_pkg::OP_AND, bpf_pkg::OP_OR, bpf_pkg::OP_XOR,
            bpf_pkg::OP_CMP, bpf_pkg::OP_SHL, bpf_pkg::OP_SHR: begin
                cls.is_binop = 1'b1;
            end
            default: begin
                cls.is_binop = 1'b0;
            end
        endcase
        case (i_arg_c)
            AW'(CC_EQ): cls.inv_op = bpf_pkg::OP_GOTO_NE;
            AW'(CC_NE): cls.inv_op = bpf_pkg::OP_GOTO_EQ;
            AW'(CC_LE): cls.inv_op = bpf_pkg::OP_GOTO_GT;
            AW'(CC_GE): cls.inv_op = bpf_pkg::OP_GOTO_LT;
            AW'(CC_LT): cls.inv_op = bpf_pkg::OP_GOTO_NLT;
            AW'(CC_GT): cls.inv_op = bpf_pkg::OP_GOTO_NGT;
            default:    cls.inv_op = bpf_pkg::OP_NONE;
        endcase
    end

    assign o_full = (r_cnt == IQ_CW'(IQ_DEPTH));
    assign o_vld  = (r_cnt != '0);
    assign wr     = i_push && !o_full;
    assign rd     = i_rd && o_vld;

    // Present the oldest queued word
    assign o_opcode = r_q_op[r_rp];
    assign o_cls    = r_q_cls[r_rp];
    assign o_arg    = r_q_arg[r_rp];
    assign o_final  = r_q_fin[r_rp];

    // Advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (wr) begin
                r_wp <= r_wp + IQ_AW'(1);
            end
            if (rd) begin
                r_rp <= r_rp + IQ_AW'(1);
            end
            r_cnt <= r_cnt + IQ_CW'(wr) - IQ_CW'(rd);
        end
    end

    // Store the accepted word
    always_ff @(posedge i_clk) begin
        if (wr) begin
            r_q_op[r_wp]     <= i_opcode;
            r_q_cls[r_wp]    <= cls;
            r_q_arg[r_wp][0] <= i_arg_a;
            r_q_arg[r_wp][1] <= i_arg_b;
            r_q_arg[r_wp][2] <= i_arg_c;
            r_q_fin[r_wp]    <= i_final;
        end
    end

endmodule

// ----- hdl/bpf_step.sv -----
// Rule matcher: one rewrite step on the head of an instruction window.
module bpf_step #(
    parameter int D  = 3,
    parameter int AW = 32,
    parameter int FW = $clog2(D + 1)
) (
    input  logic [FW-1:0]   i_fill,
    input  logic [7:0]      i_op  [D],
    input  bpf_pkg::t_class i_cls [D],
    input  logic [AW-1:0]   i_arg [D][3],
    output logic            o_emit,
    output logic [1:0]      o_consume,
    output logic [7:0]      o_op,
    output logic [AW-1:0]   o_res [3]
);

    logic has2;
    logic has3;
    logic pair_x;
    logic pair_s;
    logic r_fuse;
    logic r_swap;
    logic r_push;
    logic r_dup;
    logic r_goto;

    // Match rules on the first three slots
    always_comb begin
        has3   = (i_fill >= FW'(3));
        has2   = (i_fill >= FW'(2));
        pair_x = (i_arg[0][0] == i_arg[1][1]) && (i_arg[0][1] == i_arg[1][0]);
        pair_s = (i_arg[0][0] == i_arg[1][0]) && (i_arg[0][1] == i_arg[1][1]);
        r_fuse = has3 && i_cls[0].is_copy && i_cls[1].is_copy && i_cls[2].is_binop &&
                 (i_arg[2][1] == i_arg[0][0]) && (i_arg[2][2] == i_arg[1][0]);
        r_swap = has2 && i_cls[0].is_swap && i_cls[1].is_swap && (pair_x || pair_s);
        r_push = has2 && i_cls[0].is_copy && i_cls[1].is_push &&
                 (i_arg[0][0] == i_arg[1][0]);
        r_dup  = has2 && i_cls[0].is_copy && i_cls[1].is_copy && (pair_x || pair_s);
        r_goto = has2 && i_cls[0].is_fastcmp && i_cls[1].is_gotof &&
                 (i_arg[0][0] == i_arg[1][1]) && (i_cls[0].inv_op != bpf_pkg::OP_NONE);
    end

    // Pick the first rule that fires; default forwards the head, or drops it if it is a Nop
    always_comb begin
        o_emit    = 1'b1;
        o_consume = 2'd1;
        o_op      = i_op[0];
        o_res     = i_arg[0];
        if (r_fuse) begin
            o_consume = 2'd3;
            o_op      = i_op[2];
            o_res[0]  = i_arg[2][0];
            o_res[1]  = i_arg[0][1];
            o_res[2]  = i_arg[1][1];
        end else if (r_swap) begin
            o_emit    = 1'b0;
            o_consume = 2'd2;
        end else if (r_push) begin
            o_consume = 2'd2;
            o_op      = bpf_pkg::OP_PUSH;
            o_res[0]  = i_arg[0][1];
            o_res[1]  = '1;
            o_res[2]  = '1;
        end else if (r_dup) begin
            o_consume = 2'd2;
        end else if (r_goto) begin
            o_consume = 2'd2;
            o_op      = i_cls[0].inv_op;
            o_res[0]  = i_arg[1][0];
            o_res[1]  = i_arg[0][0];
            o_res[2]  = i_arg[0][1];
        end else if (i_cls[0].is_nop) begin
            o_emit    = 1'b0;
        end
    end

endmodule

// ----- hdl/bpf_back.sv -----
// Back end: instruction window, rewrite sequencer and result queue.
module bpf_back #(
    parameter int D  = 3,
    parameter int AW = 32
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_vld,
    output logic            o_rd,
    input  logic [7:0]      i_op,
    input  bpf_pkg::t_class i_cls,
    input  logic [AW-1:0]   i_arg [3],
    input  logic            i_final,
    output logic            o_empty,
    input  logic            i_pop,
    output logic [7:0]      o_op,
    output logic [AW-1:0]   o_arg [3],
    output logic            o_run_end,
    output logic            o_prog_end
);

    localparam int FW       = $clog2(D + 1);
    localparam int OQ_DEPTH = 4;
    localparam int OQ_AW    = $clog2(OQ_DEPTH);
    localparam int OQ_CW    = $clog2(OQ_DEPTH + 1);

    typedef enum logic [1:0] {S_RUN, S_FLUSH, S_DRAIN} t_state;

    t_state           r_state, n_state;
    logic [FW-1:0]    r_fill, n_fill;
    logic [7:0]       r_w_op  [D], n_w_op  [D];
    bpf_pkg::t_class  r_w_cls [D], n_w_cls [D];
    logic [AW-1:0]    r_w_arg [D][3], n_w_arg [D][3];
    logic             r_hold_vld, n_hold_vld;
    logic [7:0]       r_hold_op, n_hold_op;
    logic [AW-1:0]    r_hold_arg [3], n_hold_arg [3];

    logic [7:0]       r_oq_op  [OQ_DEPTH];
    logic [AW-1:0]    r_oq_arg [OQ_DEPTH][3];
    logic             r_oq_run [OQ_DEPTH];
    logic             r_oq_prog[OQ_DEPTH];
    logic [OQ_AW-1:0] r_oq_wp;
    logic [OQ_AW-1:0] r_oq_rp;
    logic [OQ_CW-1:0] r_oq_cnt;

    logic             oq_space;
    logic             oq_wr;
    logic             oq_rd;
    logic [7:0]       oq_w_op;
    logic [AW-1:0]    oq_w_arg [3];
    logic             oq_w_run;
    logic             oq_w_prog;

    logic [7:0]       v_op  [D];
    bpf_pkg::t_class  v_cls [D];
    logic [AW-1:0]    v_arg [D][3];
    logic [FW-1:0]    v_fill;

    logic [7:0]       s_op  [D];
    bpf_pkg::t_class  s_cls [D];
    logic [AW-1:0]    s_arg [D][3];
    logic [FW-1:0]    s_fill;

    logic [7:0]       sh_op  [D];
    bpf_pkg::t_class  sh_cls [D];
    logic [AW-1:0]    sh_arg [D][3];

    logic             st_emit;
    logic [1:0]       st_consume;
    logic [7:0]       st_op;
    logic [AW-1:0]    st_res [3];

    // Window with the queued word placed behind the current entries
    always_comb begin
        for (int i = 0; i < D; i++) begin
            if (FW'(i) == r_fill) begin
                v_op[i]  = i_op;
                v_cls[i] = i_cls;
                v_arg[i] = i_arg;
            end else begin
                v_op[i]  = r_w_op[i];
                v_cls[i] = r_w_cls[i];
                v_arg[i] = r_w_arg[i];
            end
        end
        v_fill = r_fill + FW'(1);
    end

    // Step on the stored window while flushing, else on the appended one
    always_comb begin
        if (r_state == S_FLUSH) begin
            s_op   = r_w_op;
            s_cls  = r_w_cls;
            s_arg  = r_w_arg;
            s_fill = r_fill;
        end else begin
            s_op   = v_op;
            s_cls  = v_cls;
            s_arg  = v_arg;
            s_fill = v_fill;
        end
    end

    bpf_step #(
        .D  (D),
        .AW (AW),
        .FW (FW)
    ) u_step (
        .i_fill    (s_fill),
        .i_op      (s_op),
        .i_cls     (s_cls),
        .i_arg     (s_arg),
        .o_emit    (st_emit),
        .o_consume (st_consume),
        .o_op      (st_op),
        .o_res     (st_res)
    );

    // Drop the consumed head entries
    always_comb begin
        sh_op  = s_op;
        sh_cls = s_cls;
        sh_arg = s_arg;
        for (int i = 0; i < D; i++) begin
            for (int k = 1; k <= 3; k++) begin
                if ((i + k < D) && (st_consume == 2'(k))) begin
                    sh_op[i]  = s_op[i + k];
                    sh_cls[i] = s_cls[i + k];
                    sh_arg[i] = s_arg[i + k];
                end
            end
        end
    end

    assign oq_space = (r_oq_cnt != OQ_CW'(OQ_DEPTH));

    // Sequence appends, flush steps and the final drain
    always_comb begin
        n_state    = r_state;
        n_fill     = r_fill;
        n_w_op     = r_w_op;
        n_w_cls    = r_w_cls;
        n_w_arg    = r_w_arg;
        n_hold_vld = r_hold_vld;
        n_hold_op  = r_hold_op;
        n_hold_arg = r_hold_arg;
        o_rd       = 1'b0;
        oq_wr      = 1'b0;
        oq_w_op    = st_op;
        oq_w_arg   = st_res;
        oq_w_run   = 1'b1;
        oq_w_prog  = 1'b0;
        case (r_state)
            S_RUN: begin
                if (i_vld && oq_space) begin
                    o_rd = 1'b1;
                    if (i_final) begin
                        n_w_op     = v_op;
                        n_w_cls    = v_cls;
                        n_w_arg    = v_arg;
                        n_fill     = v_fill;
                        n_hold_vld = 1'b0;
                        n_state    = S_FLUSH;
                    end else if (v_fill == FW'(D)) begin
                        n_w_op  = sh_op;
                        n_w_cls = sh_cls;
                        n_w_arg = sh_arg;
                        n_fill  = v_fill - FW'(st_consume);
                        oq_wr   = st_emit;
                    end else begin
                        n_w_op  = v_op;
                        n_w_cls = v_cls;
                        n_w_arg = v_arg;
                        n_fill  = v_fill;
                    end
                end
            end
            S_FLUSH: begin
                if (oq_space) begin
                    n_w_op  = sh_op;
                    n_w_cls = sh_cls;
                    n_w_arg = sh_arg;
                    n_fill  = r_fill - FW'(st_consume);
                    if (st_emit) begin
                        // release the held word; the new one may be the last
                        oq_wr      = r_hold_vld;
                        oq_w_op    = r_hold_op;
                        oq_w_arg   = r_hold_arg;
                        oq_w_run   = 1'b0;
                        n_hold_vld = 1'b1;
                        n_hold_op  = st_op;
                        n_hold_arg = st_res;
                    end
                    if (n_fill == '0) begin
                        n_state = (r_hold_vld || st_emit) ? S_DRAIN : S_RUN;
                    end
                end
            end
            S_DRAIN: begin
                if (oq_space) begin
                    oq_wr      = 1'b1;
                    oq_w_op    = r_hold_op;
                    oq_w_arg   = r_hold_arg;
                    oq_w_run   = 1'b1;
                    oq_w_prog  = 1'b1;
                    n_hold_vld = 1'b0;
                    n_state    = S_RUN;
                end
            end
            default: begin
                n_state = S_RUN;
            end
        endcase
    end

    assign o_empty = (r_oq_cnt == '0);
    assign oq_rd   = i_pop && !o_empty;

    // Present the oldest result word
    assign o_op       = r_oq_op[r_oq_rp];
    assign o_arg      = r_oq_arg[r_oq_rp];
    assign o_run_end  = r_oq_run[r_oq_rp];
    assign o_prog_end = r_oq_prog[r_oq_rp];

    // Hold state, fill and queue pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_RUN;
            r_fill     <= '0;
            r_hold_vld <= 1'b0;
            r_oq_wp    <= '0;
            r_oq_rp    <= '0;
            r_oq_cnt   <= '0;
        end else begin
            r_state    <= n_state;
            r_fill     <= n_fill;
            r_hold_vld <= n_hold_vld;
            if (oq_wr) begin
                r_oq_wp <= r_oq_wp + OQ_AW'(1);
            end
            if (oq_rd) begin
                r_oq_rp <= r_oq_rp + OQ_AW'(1);
            end
            r_oq_cnt <= r_oq_cnt + OQ_CW'(oq_wr) - OQ_CW'(oq_rd);
        end
    end

    // Window, held word and result storage
    always_ff @(posedge i_clk) begin
        r_w_op     <= n_w_op;
        r_w_cls    <= n_w_cls;
        r_w_arg    <= n_w_arg;
        r_hold_op  <= n_hold_op;
        r_hold_arg <= n_hold_arg;
        if (oq_wr) begin
            r_oq_op[r_oq_wp]   <= oq_w_op;
            r_oq_arg[r_oq_wp]  <= oq_w_arg;
            r_oq_run[r_oq_wp]  <= oq_w_run;
            r_oq_prog[r_oq_wp] <= oq_w_prog;
        end
    end

endmodule

// ----- hdl/bytecode_peephole_fuser_core.sv -----
// Top level of the bytecode peephole fuser.
//
// Instructions enter through a queue port: a word is taken on a rising edge
// with push high and full low. Results leave through a queue port: while
// empty is low the oldest result sits on the o_out_* ports and is taken on
// a rising edge with pop high. o_out_run_end marks the last result caused by
// an input word; o_out_program_end marks the last result of a procedure.
// A decode stage classifies each word into a four-entry queue; the window
// engine behind it rewrites the head of a WINDOW_DEPTH window and writes
// into a four-entry result queue, so either side may stall on its own.
// Non-final words run at one per cycle while neither queue stalls them;
// a result is written as the window engine takes the word that causes it.
// A word with i_in_final set is loaded, then up to WINDOW_DEPTH head steps
// empty the window and the last result is released. The window engine needs
// one free result slot to advance, so a receiver that stops popping fills
// the result queue and then the input queue, after which full stays high.
// Reset empties both queues and the window; no clearing pass is needed.
module bytecode_peephole_fuser_core #(
    parameter int WINDOW_DEPTH = 3,
    parameter int ARG_WIDTH    = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    output logic               full,
    input  logic [7:0]         i_in_opcode,
    input  logic signed [31:0] i_in_arg_a,
    input  logic signed [31:0] i_in_arg_b,
    input  logic signed [31:0] i_in_arg_c,
    input  logic               i_in_final,
    output logic               empty,
    input  logic               pop,
    output logic [7:0]         o_out_opcode,
    output logic signed [31:0] o_out_arg_a,
    output logic signed [31:0] o_out_arg_b,
    output logic signed [31:0] o_out_arg_c,
    output logic               o_out_run_end,
    output logic               o_out_program_end
);

    logic                 f_vld;
    logic                 f_rd;
    logic [7:0]           f_op;
    bpf_pkg::t_class      f_cls;
    logic [ARG_WIDTH-1:0] f_arg [3];
    logic                 f_final;
    logic [ARG_WIDTH-1:0] b_arg [3];

    bpf_front #(
        .AW (ARG_WIDTH)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .o_full   (full),
        .i_opcode (i_in_opcode),
        .i_arg_a  (i_in_arg_a[ARG_WIDTH-1:0]),
        .i_arg_b  (i_in_arg_b[ARG_WIDTH-1:0]),
        .i_arg_c  (i_in_arg_c[ARG_WIDTH-1:0]),
        .i_final  (i_in_final),
        .o_vld    (f_vld),
        .i_rd     (f_rd),
        .o_opcode (f_op),
        .o_cls    (f_cls),
        .o_arg    (f_arg),
        .o_final  (f_final)
    );

    bpf_back #(
        .D  (WINDOW_DEPTH),
        .AW (ARG_WIDTH)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_vld      (f_vld),
        .o_rd       (f_rd),
        .i_op       (f_op),
        .i_cls      (f_cls),
        .i_arg      (f_arg),
        .i_final    (f_final),
        .o_empty    (empty),
        .i_pop      (pop),
        .o_op       (o_out_opcode),
        .o_arg      (b_arg),
        .o_run_end  (o_out_run_end),
        .o_prog_end (o_out_program_end)
    );

    // Sign-extend arguments to the port width
    assign o_out_arg_a = 32'($signed(b_arg[0]));
    assign o_out_arg_b = 32'($signed(b_arg[1]));
    assign o_out_arg_c = 32'($signed(b_arg[2]));

endmodule

// ----- hdl/bpf_checker.sv -----
// Port-level assertions for the bytecode peephole fuser, bound to the top level.
module bpf_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       full,
    input logic       empty,
    input logic       pop,
    input logic [7:0] o_out_opcode,
    input logic       o_out_run_end,
    input logic       o_out_program_end
);

    // Reset leaves both queues empty
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> (empty && !full))
        else $error("queues not empty after reset");

    // A procedure end is always also the end of its run
    a_prog_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_out_program_end) |-> o_out_run_end)
        else $error("program end without run end");

    // Nop is never emitted
    a_no_nop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (o_out_opcode != bpf_pkg::OP_NOP))
        else $error("nop emitted");

    // Hold a stalled result
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_out_opcode) &&
                              $stable(o_out_run_end) && $stable(o_out_program_end)))
        else $error("stalled result changed");

endmodule

bind bytecode_peephole_fuser_core bpf_checker u_bpf_checker (.*);

// ----- bench/fuser_check_pkg.sv -----
`timescale 1ns / 1ps
// Instruction and result types, condition codes and the rewrite scoreboard for the fuser bench.
package fuser_check_pkg;
    import bpf_pkg::*;

    localparam int WIN_DEPTH = 3;

    // FastCompare condition codes
    localparam logic [31:0] CC_EQ  = 32'd1;
    localparam logic [31:0] CC_NE  = 32'd2;
    localparam logic [31:0] CC_LT  = 32'd4;
    localparam logic [31:0] CC_GT  = 32'd8;
    localparam logic [31:0] CC_LE  = 32'd16;
    localparam logic [31:0] CC_GE  = 32'd32;
    localparam logic [31:0] CC_BAD = 32'd3;

    localparam logic [7:0]  OP_UNUSED  = 8'hFF;
    localparam logic [31:0] ARG_UNUSED = 32'hFFFF_FFFF;

    typedef struct packed {
        logic [7:0]  opcode;
        logic [31:0] arg_a;
        logic [31:0] arg_b;
        logic [31:0] arg_c;
        logic        proc_end;
    } instr_t;

    typedef struct packed {
        logic [7:0]  opcode;
        logic [31:0] arg_a;
        logic [31:0] arg_b;
        logic [31:0] arg_c;
        logic        run_end;
        logic        program_end;
    } result_t;

    class fuser_scoreboard;
        instr_t      slot [WIN_DEPTH];
        int unsigned fill;
        result_t     expected_q [$];
        int unsigned mismatches;

        function new();
            fill = 0;
            mismatches = 0;
        endfunction

        task report_mismatch(string msg);
            $display("[%0t] mismatch: %s", $time, msg);
            mismatches++;
        endtask

        function bit is_binop(logic [7:0] op);
            case (op)
                OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD, OP_AND, OP_OR, OP_XOR,
                OP_CMP, OP_SHL, OP_SHR: return 1'b1;
                default: return 1'b0;
            endcase
        endfunction

        function logic [7:0] inverted_goto(logic [31:0] cc);
            case (cc)
                CC_EQ:   return OP_GOTO_NE;
                CC_NE:   return OP_GOTO_EQ;
                CC_LE:   return OP_GOTO_GT;
                CC_GE:   return OP_GOTO_LT;
                CC_LT:   return OP_GOTO_NLT;
                CC_GT:   return OP_GOTO_NGT;
                default: return OP_NONE;
            endcase
        endfunction

        // Same register pair, either straight or crossed
        function bit same_pair(int unsigned i, int unsigned j);
            return (slot[i].arg_a == slot[j].arg_b && slot[i].arg_b == slot[j].arg_a) ||
                   (slot[i].arg_a == slot[j].arg_a && slot[i].arg_b == slot[j].arg_b);
        endfunction

        // Shift the window left by n entries
        function void drop_head(int unsigned n);
            if (n > fill) n = fill;
            for (int unsigned i = 0; i + n < fill; i++) slot[i] = slot[i + n];
            fill -= n;
        endfunction

        function result_t make_result(logic [7:0] op, logic [31:0] a, logic [31:0] b,
                                      logic [31:0] c);
            result_t r;
            r.opcode = op;
            r.arg_a = a;
            r.arg_b = b;
            r.arg_c = c;
            r.run_end = 1'b0;
            r.program_end = 1'b0;
            return r;
        endfunction

        // Rewrite or forward the window head; returns 1 when a word is emitted
        function bit step_head(output result_t r);
            logic [7:0] op0, op1, op2, inv;
            r = '0;
            if (fill == 0) return 1'b0;
            op0 = slot[0].opcode;
            op1 = (fill >= 2) ? slot[1].opcode : OP_NONE;
            op2 = (fill >= 3) ? slot[2].opcode : OP_NONE;
            // fuse two copies into the binary op that reads both
            if (fill >= 3 && op0 == OP_COPY && op1 == OP_COPY && is_binop(op2) &&
                slot[2].arg_b == slot[0].arg_a && slot[2].arg_c == slot[1].arg_a) begin
                r = make_result(op2, slot[2].arg_a, slot[0].arg_b, slot[1].arg_b);
                drop_head(3);
                return 1'b1;
            end
            if (fill >= 2) begin
                if (op0 == OP_SWAP && op1 == OP_SWAP && same_pair(0, 1)) begin
                    drop_head(2);
                    return 1'b0;
                end
                if (op0 == OP_COPY && op1 == OP_PUSH && slot[0].arg_a == slot[1].arg_a) begin
                    r = make_result(OP_PUSH, slot[0].arg_b, ARG_UNUSED, ARG_UNUSED);
                    drop_head(2);
                    return 1'b1;
                end
                if (op0 == OP_COPY && op1 == OP_COPY && same_pair(0, 1)) begin
                    r = make_result(op0, slot[0].arg_a, slot[0].arg_b, slot[0].arg_c);
                    drop_head(2);
                    return 1'b1;
                end
                if (op0 == OP_FASTCMP && op1 == OP_GOTO_F && slot[0].arg_a == slot[1].arg_b) begin
                    inv = inverted_goto(slot[0].arg_c);
                    if (inv != OP_NONE) begin
                        r = make_result(inv, slot[1].arg_a, slot[0].arg_a, slot[0].arg_b);
                        drop_head(2);
                        return 1'b1;
                    end
                end
            end
            // forward anything else, drop a Nop
            if (op0 != OP_NOP) begin
                r = make_result(op0, slot[0].arg_a, slot[0].arg_b, slot[0].arg_c);
                drop_head(1);
                return 1'b1;
            end
            drop_head(1);
            return 1'b0;
        endfunction

        // Take one accepted word and queue the results it causes
        function void note_input(instr_t w);
            result_t run [$];
            result_t r;
            if (fill >= WIN_DEPTH) begin
                if (step_head(r)) run.push_back(r);
            end
            slot[fill] = w;
            fill++;
            if (w.proc_end) begin
                while (fill > 0) begin
                    if (step_head(r)) run.push_back(r);
                end
            end else if (fill >= WIN_DEPTH) begin
                if (step_head(r)) run.push_back(r);
            end
            if (run.size() > 0) begin
                r = run[run.size() - 1];
                r.run_end = 1'b1;
                r.program_end = w.proc_end;
                run[run.size() - 1] = r;
            end
            foreach (run[i]) expected_q.push_back(run[i]);
        endfunction

        task check_result(result_t got);
            result_t want;
            if (expected_q.size() == 0) begin
                report_mismatch($sformatf("unexpected result, opcode %02h", got.opcode));
                return;
            end
            want = expected_q.pop_front();
            if (got.opcode !== want.opcode)
                report_mismatch($sformatf("opcode %02h, want %02h", got.opcode, want.opcode));
            if (got.arg_a !== want.arg_a)
                report_mismatch($sformatf("arg_a %08h, want %08h", got.arg_a, want.arg_a));
            if (got.arg_b !== want.arg_b)
                report_mismatch($sformatf("arg_b %08h, want %08h", got.arg_b, want.arg_b));
            if (got.arg_c !== want.arg_c)
                report_mismatch($sformatf("arg_c %08h, want %08h", got.arg_c, want.arg_c));
            if (got.run_end !== want.run_end)
                report_mismatch($sformatf("run_end %b, want %b", got.run_end, want.run_end));
            if (got.program_end !== want.program_end)
                report_mismatch($sformatf("program_end %b, want %b",
                                          got.program_end, want.program_end));
        endtask

        function int unsigned pending();
            return expected_q.size();
        endfunction

        task report_leftovers();
            foreach (expected_q[i])
                report_mismatch($sformatf("result never came, opcode %02h",
                                          expected_q[i].opcode));
        endtask
    endclass

endpackage

// ----- bench/tb_top.sv -----
`timescale 1ns / 1ps
// Top-level bench for the peephole fuser: drives instruction words and checks each result.
module tb_top;
    import bpf_pkg::*;
    import fuser_check_pkg::*;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               push = 1'b0;
    logic               full;
    logic [7:0]         i_in_opcode = '0;
    logic signed [31:0] i_in_arg_a = '0;
    logic signed [31:0] i_in_arg_b = '0;
    logic signed [31:0] i_in_arg_c = '0;
    logic               i_in_final = 1'b0;
    logic               empty;
    logic               pop = 1'b0;
    logic [7:0]         o_out_opcode;
    logic signed [31:0] o_out_arg_a;
    logic signed [31:0] o_out_arg_b;
    logic signed [31:0] o_out_arg_c;
    logic               o_out_run_end;
    logic               o_out_program_end;

    fuser_scoreboard fuse_sb;
    int              send_idle_pct = 0;
    int              recv_idle_pct = 0;
    int unsigned     words_sent = 0;

    bytecode_peephole_fuser_core DUT (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .push              (push),
        .full              (full),
        .i_in_opcode       (i_in_opcode),
        .i_in_arg_a        (i_in_arg_a),
        .i_in_arg_b        (i_in_arg_b),
        .i_in_arg_c        (i_in_arg_c),
        .i_in_final        (i_in_final),
        .empty             (empty),
        .pop               (pop),
        .o_out_opcode      (o_out_opcode),
        .o_out_arg_a       (o_out_arg_a),
        .o_out_arg_b       (o_out_arg_b),
        .o_out_arg_c       (o_out_arg_c),
        .o_out_run_end     (o_out_run_end),
        .o_out_program_end (o_out_program_end)
    );

    always #5 i_clk = ~i_clk;

    // Hard stop in case the block hangs
    initial begin
        #2_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    // Check each popped word, then pick pop for the next cycle
    always @(posedge i_clk) begin : drain_results
        result_t seen;
        if (i_rst_n) begin
            if (pop && !empty) begin
                seen.opcode = o_out_opcode;
                seen.arg_a = o_out_arg_a;
                seen.arg_b = o_out_arg_b;
                seen.arg_c = o_out_arg_c;
                seen.run_end = o_out_run_end;
                seen.program_end = o_out_program_end;
                fuse_sb.check_result(seen);
            end
            pop <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    function automatic instr_t mk(logic [7:0] op, logic [31:0] a, logic [31:0] b,
                                  logic [31:0] c, logic fin);
        instr_t w;
        w.opcode = op;
        w.arg_a = a;
        w.arg_b = b;
        w.arg_c = c;
        w.proc_end = fin;
        return w;
    endfunction

    // Mostly small register numbers so patterns match by chance too
    function automatic logic [31:0] pick_reg();
        return ($urandom_range(3) == 0) ? $urandom : $urandom_range(7);
    endfunction

    function automatic logic [31:0] any_arg();
        return $urandom_range(1) ? ARG_UNUSED : $urandom;
    endfunction

    function automatic logic [7:0] pick_binop();
        case ($urandom_range(10))
            0:       return OP_ADD;
            1:       return OP_SUB;
            2:       return OP_MUL;
            3:       return OP_DIV;
            4:       return OP_MOD;
            5:       return OP_SHR;
            6:       return OP_SHL;
            7:       return OP_OR;
            8:       return OP_AND;
            9:       return OP_XOR;
            default: return OP_CMP;
        endcase
    endfunction

    function automatic logic [7:0] pick_known_op();
        case ($urandom_range(12))
            0:       return OP_COPY;
            1:       return OP_PUSH;
            2:       return OP_NOP;
            3:       return OP_SWAP;
            4:       return OP_FASTCMP;
            5:       return OP_GOTO_F;
            6:       return OP_GOTO_EQ;
            7:       return OP_GOTO_NE;
            8:       return OP_GOTO_GT;
            9:       return OP_GOTO_LT;
            10:      return OP_GOTO_NGT;
            11:      return OP_GOTO_NLT;
            default: return pick_binop();
        endcase
    endfunction

    function automatic logic [31:0] pick_cc();
        case ($urandom_range(7))
            0:       return CC_EQ;
            1:       return CC_NE;
            2:       return CC_LT;
            3:       return CC_GT;
            4:       return CC_LE;
            5:       return CC_GE;
            6:       return CC_BAD;
            default: return $urandom;
        endcase
    endfunction

    // Offer one word, idling at random first; note it once it is taken
    task automatic send_word(instr_t w);
        while ($urandom_range(99) < send_idle_pct) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push <= 1'b1;
        i_in_opcode <= w.opcode;
        i_in_arg_a <= w.arg_a;
        i_in_arg_b <= w.arg_b;
        i_in_arg_c <= w.arg_c;
        i_in_final <= w.proc_end;
        do @(posedge i_clk); while (full !== 1'b0);
        fuse_sb.note_input(w);
        words_sent++;
    endtask

    // Hold the sender until every expected word is out, then let the window settle
    task automatic hold_until_drained();
        push <= 1'b0;
        do @(posedge i_clk); while (fuse_sb.pending() != 0);
        repeat (10) @(posedge i_clk);
    endtask

    // Build one rewrite pattern with random registers, sometimes broken or final
    task automatic send_fragment();
        instr_t      frag [$];
        instr_t      w;
        logic [31:0] r0, r1, r2, r3, flip;
        int unsigned at;
        r0 = pick_reg();
        r1 = pick_reg();
        r2 = pick_reg();
        r3 = pick_reg();
        case ($urandom_range(11))
            0, 1: begin
                frag.push_back(mk(OP_COPY, r0, r1, any_arg(), 1'b0));
                frag.push_back(mk(OP_COPY, r2, r3, any_arg(), 1'b0));
                frag.push_back(mk(pick_binop(), pick_reg(), r0, r2, 1'b0));
            end
            2: begin
                frag.push_back(mk(OP_SWAP, r0, r1, any_arg(), 1'b0));
                if ($urandom_range(1))
                    frag.push_back(mk(OP_SWAP, r1, r0, any_arg(), 1'b0));
                else
                    frag.push_back(mk(OP_SWAP, r0, r1, any_arg(), 1'b0));
            end
            3: begin
                frag.push_back(mk(OP_COPY, r0, r1, any_arg(), 1'b0));
                frag.push_back(mk(OP_PUSH, r0, any_arg(), any_arg(), 1'b0));
            end
            4: begin
                frag.push_back(mk(OP_COPY, r0, r1, any_arg(), 1'b0));
                frag.push_back(mk(OP_COPY, r1, r0, any_arg(), 1'b0));
            end
            5: begin
                frag.push_back(mk(OP_COPY, r0, r1, any_arg(), 1'b0));
                frag.push_back(mk(OP_COPY, r0, r1, any_arg(), 1'b0));
            end
            6, 7: begin
                frag.push_back(mk(OP_FASTCMP, r0, r1, pick_cc(), 1'b0));
                frag.push_back(mk(OP_GOTO_F, $urandom, r0, any_arg(), 1'b0));
            end
            8: frag.push_back(mk(OP_NOP, any_arg(), any_arg(), any_arg(), 1'b0));
            9: frag.push_back(mk(8'($urandom_range(255)), $urandom, $urandom, $urandom, 1'b0));
            10: frag.push_back(mk(pick_known_op(), r0, r1, r2, 1'b0));
            default: begin
                frag.push_back(mk(pick_known_op(), r0, r1, r2, 1'b0));
                frag.push_back(mk(pick_known_op(), r2, r3, r0, 1'b0));
            end
        endcase
        // break the pattern now and then
        if ($urandom_range(4) == 0) begin
            at = $urandom_range(frag.size() - 1);
            w = frag[at];
            flip = 32'h1 << $urandom_range(2);
            case ($urandom_range(2))
                0:       w.arg_a = w.arg_a ^ flip;
                1:       w.arg_b = w.arg_b ^ flip;
                default: w.arg_c = w.arg_c ^ flip;
            endcase
            frag[at] = w;
        end
        // end the procedure here now and then
        if ($urandom_range(7) == 0) begin
            w = frag[frag.size() - 1];
            w.proc_end = 1'b1;
            frag[frag.size() - 1] = w;
        end
        foreach (frag[i]) send_word(frag[i]);
    endtask

    task automatic run_phase(int s_pct, int r_pct, int unsigned n);
        int unsigned stop_at;
        send_idle_pct = s_pct;
        recv_idle_pct = r_pct;
        stop_at = words_sent + n;
        while (words_sent < stop_at) send_fragment();
        hold_until_drained();
    endtask

    initial begin
        fuse_sb = new();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: each rewrite rule, its near misses and the flush cases
        send_word(mk(OP_COPY, 1, 2, 0, 1'b0));
        send_word(mk(OP_COPY, 3, 4, 0, 1'b0));
        send_word(mk(OP_ADD, 5, 1, 3, 1'b0));
        send_word(mk(OP_SWAP, 1, 2, 0, 1'b0));
        send_word(mk(OP_SWAP, 2, 1, 0, 1'b0));
        send_word(mk(OP_COPY, 7, 8, 0, 1'b0));
        send_word(mk(OP_PUSH, 7, ARG_UNUSED, ARG_UNUSED, 1'b0));
        send_word(mk(OP_COPY, 1, 2, 0, 1'b0));
        send_word(mk(OP_COPY, 2, 1, 0, 1'b0));
        send_word(mk(OP_COPY, 1, 2, 0, 1'b0));
        send_word(mk(OP_COPY, 1, 2, 0, 1'b0));
        send_word(mk(OP_FASTCMP, 9, 10, CC_LT, 1'b0));
        send_word(mk(OP_GOTO_F, 100, 9, ARG_UNUSED, 1'b0));
        send_word(mk(OP_NOP, 0, 0, 0, 1'b0));
        send_word(mk(OP_FASTCMP, 9, 10, CC_BAD, 1'b0));
        send_word(mk(OP_GOTO_F, 100, 9, ARG_UNUSED, 1'b0));
        send_word(mk(OP_UNUSED, 32'h7FFF_FFFF, 32'h8000_0000, ARG_UNUSED, 1'b0));
        send_word(mk(OP_NONE, 32'h8000_0000, 32'h7FFF_FFFF, 0, 1'b1));
        send_word(mk(OP_NOP, 0, 0, 0, 1'b1));
        send_word(mk(OP_SWAP, 5, 6, 0, 1'b0));
        send_word(mk(OP_SWAP, 5, 6, 0, 1'b1));
        send_word(mk(OP_COPY, 1, 2, 0, 1'b0));
        send_word(mk(OP_COPY, 3, 4, 0, 1'b0));
        send_word(mk(OP_MUL, 9, 1, 3, 1'b1));
        hold_until_drained();

        // random traffic under three idling mixes
        run_phase(24, 84, 120);
        run_phase(84, 24, 115);
        run_phase(0, 0, 115);

        fuse_sb.report_leftovers();
        if (fuse_sb.mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
